// ===== rtl/stt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

   localparam int MAX_LINE_DEFAULT = 1024;

   // result queue between the scanner and the result port
   localparam int RESULT_DEPTH = 4;
   localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);
   localparam int RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);

   localparam logic [2:0] TOKEN_IDENT    = 3'd0;
   localparam logic [2:0] TOKEN_KEYWORD  = 3'd1;
   localparam logic [2:0] TOKEN_INTEGER  = 3'd2;
   localparam logic [2:0] TOKEN_FLOAT    = 3'd3;
   localparam logic [2:0] TOKEN_STRING   = 3'd4;
   localparam logic [2:0] TOKEN_OPERATOR = 3'd5;
   localparam logic [2:0] TOKEN_SEPARATOR = 3'd6;

   localparam logic [7:0] CHAR_V       = 8'h76;
   localparam logic [7:0] CHAR_A       = 8'h61;
   localparam logic [7:0] CHAR_R       = 8'h72;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK  = 8'h5D;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_PIPE    = 8'h7C;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;

   typedef struct packed {
      logic [2:0]  token_class;
      logic [15:0] line_number;
      logic [9:0]  start_column;
      logic [9:0]  token_length;
      logic        error_flag;
      logic        last_result;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_NEWLINE);
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return c inside {CHAR_LPAREN, CHAR_RPAREN, CHAR_LBRACK, CHAR_RBRACK,
                       CHAR_LBRACE, CHAR_RBRACE, CHAR_SEMI, CHAR_COMMA};
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return c inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH, CHAR_COLON,
                       CHAR_AMP, CHAR_PIPE, CHAR_BANG, CHAR_DOT, CHAR_EQUAL};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CHAR_ZERO:CHAR_NINE]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/source_text_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// an accepted character is registered, then its results are written to the result queue
// throughput: one character per cycle when not stalled; a character that yields two
//   tokens writes both into the four-entry result queue, which feeds the result port
// the scanner stalls the input only when the result queue has fewer than two free slots
// reset: synchronous, clears scan state to idle, line 1, column 0, and empties the queue
module source_text_tokenizer #(
   parameter int MAX_LINE = stt_pkg::MAX_LINE_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_token_class,
   output logic [15:0]      rsp_line_number,
   output logic [9:0]       rsp_start_column,
   output logic [9:0]       rsp_token_length,
   output logic             rsp_error_flag,
   output logic             rsp_last_result
);

   localparam logic [9:0] COL_TOP = (MAX_LINE > 1024) ? 10'd1023 : 10'(MAX_LINE - 1);
   localparam int DEPTH = stt_pkg::RESULT_DEPTH;
   localparam int PTR_W = stt_pkg::RESULT_PTR_W;
   localparam int CNT_W = stt_pkg::RESULT_CNT_W;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_KEY,
      MODE_NZERO,
      MODE_NINT,
      MODE_NFRAC,
      MODE_SDQ,
      MODE_SSQ,
      MODE_ERR
   } mode_type;

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] ch_ff;
   logic       eoi_ff;
   logic       accept;
   logic       proc;
   logic       can_process;

   // scan state
   mode_type    mode_ff, mode_in;
   logic [1:0]  kp_ff, kp_in;
   logic [9:0]  ts_ff, ts_in;
   logic [9:0]  col_ff, col_in;
   logic [15:0] line_ff, line_in;

   // result queue
   stt_pkg::result_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             pop;

   stt_pkg::result_type res_a, res_b, err_res, pend_res;
   logic [1:0] n_res;
   logic       pend_valid;
   logic       is_num;
   logic       delim;
   logic       start_idle;
   logic [9:0] pend_len;

   assign can_process = count_ff <= CNT_W'(DEPTH - 2);
   assign proc        = in_valid_ff && can_process;
   assign req_stall   = in_valid_ff && !can_process;
   assign accept      = req_valid && !req_stall;
   assign pop         = rsp_valid && !rsp_stall;

   assign rsp_valid = count_ff != '0;
   assign rsp_token_class  = mem_ff[rd_ptr_ff].token_class;
   assign rsp_line_number  = mem_ff[rd_ptr_ff].line_number;
   assign rsp_start_column = mem_ff[rd_ptr_ff].start_column;
   assign rsp_token_length = mem_ff[rd_ptr_ff].token_length;
   assign rsp_error_flag   = mem_ff[rd_ptr_ff].error_flag;
   assign rsp_last_result  = mem_ff[rd_ptr_ff].last_result;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
   end

   // fixed-form results for the pending word or number and for an error
   always_comb begin
      pend_len = (col_ff >= ts_ff) ? (col_ff - ts_ff) : 10'd0;
      pend_valid = 1'b1;
      pend_res = '0;
      pend_res.line_number  = line_ff;
      pend_res.start_column = ts_ff;
      pend_res.token_length = pend_len;
      case (mode_ff)
         MODE_IDENT:  pend_res.token_class = stt_pkg::TOKEN_IDENT;
         MODE_KEY:    pend_res.token_class = (kp_ff == 2'd3) ? stt_pkg::TOKEN_KEYWORD
                                                             : stt_pkg::TOKEN_IDENT;
         MODE_NZERO,
         MODE_NINT:   pend_res.token_class = stt_pkg::TOKEN_INTEGER;
         MODE_NFRAC:  pend_res.token_class = stt_pkg::TOKEN_FLOAT;
         default:     pend_valid = 1'b0;
      endcase
      err_res = '0;
      err_res.line_number  = line_ff;
      err_res.start_column = col_ff;
      err_res.error_flag   = 1'b1;
   end

   // one pass of the scanner per character
   always_comb begin
      mode_in = mode_ff;
      kp_in   = kp_ff;
      ts_in   = ts_ff;
      col_in  = col_ff;
      line_in = line_ff;
      res_a   = '0;
      res_b   = '0;
      n_res   = 2'd0;
      start_idle = 1'b0;
      is_num  = (mode_ff == MODE_NZERO) || (mode_ff == MODE_NINT) || (mode_ff == MODE_NFRAC);
      delim   = stt_pkg::is_space(ch_ff) || stt_pkg::is_sep(ch_ff) ||
                (stt_pkg::is_op(ch_ff) && !(is_num && ch_ff == stt_pkg::CHAR_DOT));
      if (proc) begin
         if (eoi_ff) begin
            if (mode_ff == MODE_SDQ || mode_ff == MODE_SSQ) begin
               res_a = err_res;
               n_res = 2'd1;
            end else if (pend_valid) begin
               res_a = pend_res;
               n_res = 2'd1;
            end
            mode_in = MODE_IDLE;
            kp_in   = 2'd0;
            ts_in   = 10'd0;
            col_in  = 10'd0;
            line_in = 16'd1;
         end else if (mode_ff != MODE_ERR) begin
            case (mode_ff)
               MODE_SDQ, MODE_SSQ: begin
                  if ((ch_ff == stt_pkg::CHAR_DQUOTE && mode_ff == MODE_SDQ) ||
                      (ch_ff == stt_pkg::CHAR_SQUOTE && mode_ff == MODE_SSQ)) begin
                     res_a = '0;
                     res_a.token_class  = stt_pkg::TOKEN_STRING;
                     res_a.line_number  = line_ff;
                     res_a.start_column = ts_ff;
                     res_a.token_length = pend_len;
                     n_res   = 2'd1;
                     mode_in = MODE_IDLE;
                  end else if (ch_ff == stt_pkg::CHAR_NEWLINE) begin
                     res_a   = err_res;
                     n_res   = 2'd1;
                     mode_in = MODE_ERR;
                  end
               end
               MODE_IDENT, MODE_KEY, MODE_NZERO, MODE_NINT, MODE_NFRAC: begin
                  if (delim) begin
                     res_a      = pend_res;
                     n_res      = 2'd1;
                     mode_in    = MODE_IDLE;
                     kp_in      = 2'd0;
                     start_idle = 1'b1;
                  end else if (mode_ff == MODE_KEY) begin
                     if (kp_ff == 2'd1 && ch_ff == stt_pkg::CHAR_A) begin
                        kp_in = 2'd2;
                     end else if (kp_ff == 2'd2 && ch_ff == stt_pkg::CHAR_R) begin
                        kp_in = 2'd3;
                     end else begin
                        mode_in = MODE_IDENT;
                        kp_in   = 2'd0;
                     end
                  end else if (is_num) begin
                     if (ch_ff == stt_pkg::CHAR_DOT && mode_ff != MODE_NFRAC) begin
                        mode_in = MODE_NFRAC;
                     end else if (!(stt_pkg::is_digit(ch_ff) && mode_ff != MODE_NZERO)) begin
                        res_a   = err_res;
                        n_res   = 2'd1;
                        mode_in = MODE_ERR;
                     end
                  end
               end
               default: begin
                  mode_in    = MODE_IDLE;
                  start_idle = 1'b1;
               end
            endcase

            // a fresh token starts, or a delimiter forms its own token
            if (start_idle) begin
               if (stt_pkg::is_digit(ch_ff)) begin
                  ts_in   = col_ff;
                  mode_in = (ch_ff == stt_pkg::CHAR_ZERO) ? MODE_NZERO : MODE_NINT;
               end else if (ch_ff == stt_pkg::CHAR_V) begin
                  ts_in   = col_ff;
                  mode_in = MODE_KEY;
                  kp_in   = 2'd1;
               end else if (ch_ff == stt_pkg::CHAR_DQUOTE || ch_ff == stt_pkg::CHAR_SQUOTE) begin
                  ts_in   = (col_ff < COL_TOP) ? (col_ff + 10'd1) : COL_TOP;
                  mode_in = (ch_ff == stt_pkg::CHAR_DQUOTE) ? MODE_SDQ : MODE_SSQ;
               end else if (stt_pkg::is_op(ch_ff) || stt_pkg::is_sep(ch_ff)) begin
                  res_b = '0;
                  res_b.token_class  = stt_pkg::is_op(ch_ff) ? stt_pkg::TOKEN_OPERATOR
                                                             : stt_pkg::TOKEN_SEPARATOR;
                  res_b.line_number  = line_ff;
                  res_b.start_column = col_ff;
                  res_b.token_length = 10'd1;
                  if (n_res == 2'd0) begin
                     res_a = res_b;
                     n_res = 2'd1;
                  end else begin
                     n_res = 2'd2;
                  end
               end else if (!stt_pkg::is_space(ch_ff)) begin
                  ts_in   = col_ff;
                  mode_in = MODE_IDENT;
               end
            end

            if (ch_ff == stt_pkg::CHAR_NEWLINE) begin
               col_in = 10'd0;
               if (line_ff != 16'hFFFF) begin
                  line_in = line_ff + 16'd1;
               end
            end else if (col_ff < COL_TOP) begin
               col_in = col_ff + 10'd1;
            end
         end
      end
      if (n_res == 2'd2) begin
         res_b.last_result = 1'b1;
      end else if (n_res == 2'd1) begin
         res_a.last_result = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         kp_ff       <= 2'd0;
         ts_ff       <= 10'd0;
         col_ff      <= 10'd0;
         line_ff     <= 16'd1;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         kp_ff       <= kp_in;
         ts_ff       <= ts_in;
         col_ff      <= col_in;
         line_ff     <= line_in;
         wr_ptr_ff   <= wr_ptr_ff + PTR_W'(n_res);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + CNT_W'(n_res) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff  <= req_ch;
         eoi_ff <= req_end_of_input;
      end
      if (n_res != 2'd0) begin
         mem_ff[wr_ptr_ff] <= res_a;
      end
      if (n_res == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= res_b;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overflow");

   a_eoi_restart: assert property (@(posedge clock) disable iff (reset)
      proc && eoi_ff |=> mode_ff == MODE_IDLE && line_ff == 16'd1 && col_ff == 10'd0)
      else $error("end of input did not restart the scan");

   a_err_silent: assert property (@(posedge clock) disable iff (reset)
      proc && !eoi_ff && mode_ff == MODE_ERR |-> n_res == 2'd0 && mode_in == MODE_ERR)
      else $error("results produced while dropping after an error");

   a_second_is_delim: assert property (@(posedge clock) disable iff (reset)
      n_res == 2'd2 |-> (res_b.token_class == stt_pkg::TOKEN_OPERATOR ||
                         res_b.token_class == stt_pkg::TOKEN_SEPARATOR) && !res_a.last_result)
      else $error("second result of a beat is not a delimiter token");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_TOP && ts_ff <= COL_TOP)
      else $error("column past saturation limit");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned ERROR_PRINT_MAX = 40;
   localparam logic [9:0]  COLUMN_TOP =
      10'((stt_pkg::MAX_LINE_DEFAULT > 1024) ? 1023 : stt_pkg::MAX_LINE_DEFAULT - 1);

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_KEYWORD, SCAN_ZERO, SCAN_INT, SCAN_FRAC,
      SCAN_DQUOTE, SCAN_SQUOTE, SCAN_ERROR
   } scan_mode_type;

   typedef enum int {CLOSE_QUOTE, CLOSE_NEWLINE, CLOSE_END} string_end_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_ch = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_token_class;
   logic [15:0] rsp_line_number;
   logic [9:0]  rsp_start_column;
   logic [9:0]  rsp_token_length;
   logic        rsp_error_flag;
   logic        rsp_last_result;

   source_text_tokenizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_class  (rsp_token_class),
      .rsp_line_number  (rsp_line_number),
      .rsp_start_column (rsp_start_column),
      .rsp_token_length (rsp_token_length),
      .rsp_error_flag   (rsp_error_flag),
      .rsp_last_result  (rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned chars_sent = 0;
   int unsigned tokens_checked = 0;
   int unsigned error_tokens_seen = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;

   stt_pkg::result_type expected_tokens[$];

   // scanner copy kept in step with the block
   scan_mode_type        scan_mode = SCAN_IDLE;
   logic [1:0]           kw_seen = 2'd0;
   logic [9:0]           tok_start = 10'd0;
   logic [9:0]           col_now = 10'd0;
   logic [15:0]          line_now = 16'd1;
   stt_pkg::result_type  step_out [2];
   int                   step_n;

   function automatic bit blank_char(logic [7:0] c);
      return c == stt_pkg::CHAR_SPACE || c == stt_pkg::CHAR_NEWLINE;
   endfunction

   function automatic bit separator_char(logic [7:0] c);
      case (c)
         stt_pkg::CHAR_LPAREN, stt_pkg::CHAR_RPAREN, stt_pkg::CHAR_LBRACK,
         stt_pkg::CHAR_RBRACK, stt_pkg::CHAR_LBRACE, stt_pkg::CHAR_RBRACE,
         stt_pkg::CHAR_SEMI, stt_pkg::CHAR_COMMA: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit operator_char(logic [7:0] c);
      case (c)
         stt_pkg::CHAR_PLUS, stt_pkg::CHAR_MINUS, stt_pkg::CHAR_STAR,
         stt_pkg::CHAR_SLASH, stt_pkg::CHAR_COLON, stt_pkg::CHAR_AMP,
         stt_pkg::CHAR_PIPE, stt_pkg::CHAR_BANG, stt_pkg::CHAR_DOT,
         stt_pkg::CHAR_EQUAL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit digit_char(logic [7:0] c);
      return c >= stt_pkg::CHAR_ZERO && c <= stt_pkg::CHAR_NINE;
   endfunction

   function automatic logic [9:0] span_to(logic [9:0] col);
      return (col >= tok_start) ? col - tok_start : 10'd0;
   endfunction

   function automatic void emit_token(logic [2:0] cls, logic [9:0] col,
                                      logic [9:0] len, logic err);
      step_out[step_n] = '{token_class: cls, line_number: line_now,
                           start_column: col, token_length: len,
                           error_flag: err, last_result: 1'b0};
      step_n++;
   endfunction

   function automatic void close_token(logic [9:0] col);
      logic [2:0] cls;
      case (scan_mode)
         SCAN_WORD:           cls = stt_pkg::TOKEN_IDENT;
         SCAN_KEYWORD:        cls = (kw_seen == 2'd3) ? stt_pkg::TOKEN_KEYWORD
                                                      : stt_pkg::TOKEN_IDENT;
         SCAN_ZERO, SCAN_INT: cls = stt_pkg::TOKEN_INTEGER;
         SCAN_FRAC:           cls = stt_pkg::TOKEN_FLOAT;
         default:             return;
      endcase
      emit_token(cls, tok_start, span_to(col), 1'b0);
      scan_mode = SCAN_IDLE;
      kw_seen = 2'd0;
   endfunction

   function automatic void restart_scan();
      scan_mode = SCAN_IDLE;
      kw_seen = 2'd0;
      tok_start = 10'd0;
      col_now = 10'd0;
      line_now = 16'd1;
   endfunction

   // tokens completed by one accepted character beat
   function automatic void predict_tokens(logic [7:0] c, logic eoi);
      logic [9:0] col;
      bit         in_number;
      bit         string_closed;
      col = col_now;
      step_n = 0;
      string_closed = 1'b0;
      if (eoi) begin
         if (scan_mode == SCAN_DQUOTE || scan_mode == SCAN_SQUOTE)
            emit_token(stt_pkg::TOKEN_IDENT, col, 10'd0, 1'b1);
         else
            close_token(col);
         restart_scan();
      end else if (scan_mode != SCAN_ERROR) begin
         case (scan_mode)
            SCAN_DQUOTE, SCAN_SQUOTE: begin
               if ((scan_mode == SCAN_DQUOTE && c == stt_pkg::CHAR_DQUOTE) ||
                   (scan_mode == SCAN_SQUOTE && c == stt_pkg::CHAR_SQUOTE)) begin
                  emit_token(stt_pkg::TOKEN_STRING, tok_start, span_to(col), 1'b0);
                  scan_mode = SCAN_IDLE;
                  string_closed = 1'b1;
               end else if (c == stt_pkg::CHAR_NEWLINE) begin
                  emit_token(stt_pkg::TOKEN_IDENT, col, 10'd0, 1'b1);
                  scan_mode = SCAN_ERROR;
               end
            end
            SCAN_IDLE: ;
            default: begin
               in_number = scan_mode == SCAN_ZERO || scan_mode == SCAN_INT ||
                           scan_mode == SCAN_FRAC;
               // a dot inside a number belongs to the number
               if (blank_char(c) || separator_char(c) ||
                   (operator_char(c) && !(in_number && c == stt_pkg::CHAR_DOT))) begin
                  close_token(col);
               end else if (scan_mode == SCAN_KEYWORD) begin
                  if (kw_seen == 2'd1 && c == stt_pkg::CHAR_A) kw_seen = 2'd2;
                  else if (kw_seen == 2'd2 && c == stt_pkg::CHAR_R) kw_seen = 2'd3;
                  else begin
                     scan_mode = SCAN_WORD;
                     kw_seen = 2'd0;
                  end
               end else if (in_number) begin
                  if (c == stt_pkg::CHAR_DOT && scan_mode != SCAN_FRAC) begin
                     scan_mode = SCAN_FRAC;
                  end else if (!(digit_char(c) && scan_mode != SCAN_ZERO)) begin
                     emit_token(stt_pkg::TOKEN_IDENT, col, 10'd0, 1'b1);
                     scan_mode = SCAN_ERROR;
                  end
               end
            end
         endcase
         // the quote that closes a string does not open another one
         if (scan_mode == SCAN_IDLE && !string_closed) begin
            if (digit_char(c)) begin
               tok_start = col;
               scan_mode = (c == stt_pkg::CHAR_ZERO) ? SCAN_ZERO : SCAN_INT;
            end else if (c == stt_pkg::CHAR_V) begin
               tok_start = col;
               scan_mode = SCAN_KEYWORD;
               kw_seen = 2'd1;
            end else if (c == stt_pkg::CHAR_DQUOTE || c == stt_pkg::CHAR_SQUOTE) begin
               tok_start = (col < COLUMN_TOP) ? col + 10'd1 : COLUMN_TOP;
               scan_mode = (c == stt_pkg::CHAR_DQUOTE) ? SCAN_DQUOTE : SCAN_SQUOTE;
            end else if (operator_char(c)) begin
               emit_token(stt_pkg::TOKEN_OPERATOR, col, 10'd1, 1'b0);
            end else if (separator_char(c)) begin
               emit_token(stt_pkg::TOKEN_SEPARATOR, col, 10'd1, 1'b0);
            end else if (!blank_char(c)) begin
               tok_start = col;
               scan_mode = SCAN_WORD;
            end
         end
         if (c == stt_pkg::CHAR_NEWLINE) begin
            col_now = 10'd0;
            if (line_now != 16'hFFFF) line_now++;
         end else if (col_now < COLUMN_TOP) begin
            col_now++;
         end
      end
      if (step_n > 0) step_out[step_n - 1].last_result = 1'b1;
      for (int i = 0; i < step_n; i++) expected_tokens.push_back(step_out[i]);
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic void check_field(string name, int unsigned want,
                                       int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= ERROR_PRINT_MAX)
            $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      stt_pkg::result_type got;
      stt_pkg::result_type want;
      got = '{rsp_token_class, rsp_line_number, rsp_start_column,
              rsp_token_length, rsp_error_flag, rsp_last_result};
      if (!reset && rsp_valid && !rsp_stall) begin
         tokens_checked++;
         if (expected_tokens.size() == 0) begin
            error_count++;
            if (error_count <= ERROR_PRINT_MAX)
               $error("unexpected token: class %0d line %0d column %0d length %0d",
                      got.token_class, got.line_number, got.start_column,
                      got.token_length);
         end else begin
            want = expected_tokens.pop_front();
            if (want.error_flag) error_tokens_seen++;
            check_field("token_class", want.token_class, got.token_class);
            check_field("line_number", want.line_number, got.line_number);
            check_field("start_column", want.start_column, got.start_column);
            check_field("token_length", want.token_length, got.token_length);
            check_field("error_flag", want.error_flag, got.error_flag);
            check_field("last_result", want.last_result, got.last_result);
         end
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** source_text_tokenizer: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input logic eoi = 1'b0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tokens(c, eoi);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   // character is ignored on an end-of-input beat, so it is random
   task automatic send_end();
      send_char(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] random_digit();
      return 8'(stt_pkg::CHAR_ZERO + $urandom_range(9));
   endfunction

   function automatic logic [7:0] random_word_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (blank_char(c) || separator_char(c) || operator_char(c));
      return c;
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(9))
         0: return stt_pkg::CHAR_PLUS;
         1: return stt_pkg::CHAR_MINUS;
         2: return stt_pkg::CHAR_STAR;
         3: return stt_pkg::CHAR_SLASH;
         4: return stt_pkg::CHAR_COLON;
         5: return stt_pkg::CHAR_AMP;
         6: return stt_pkg::CHAR_PIPE;
         7: return stt_pkg::CHAR_BANG;
         8: return stt_pkg::CHAR_DOT;
         default: return stt_pkg::CHAR_EQUAL;
      endcase
   endfunction

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(7))
         0: return stt_pkg::CHAR_LPAREN;
         1: return stt_pkg::CHAR_RPAREN;
         2: return stt_pkg::CHAR_LBRACK;
         3: return stt_pkg::CHAR_RBRACK;
         4: return stt_pkg::CHAR_LBRACE;
         5: return stt_pkg::CHAR_RBRACE;
         6: return stt_pkg::CHAR_SEMI;
         default: return stt_pkg::CHAR_COMMA;
      endcase
   endfunction

   function automatic logic [7:0] pick_delimiter(bit after_number);
      logic [7:0] c;
      do begin
         case ($urandom_range(3))
            0: c = stt_pkg::CHAR_SPACE;
            1: c = stt_pkg::CHAR_NEWLINE;
            2: c = pick_operator();
            default: c = pick_separator();
         endcase
      end while (after_number && c == stt_pkg::CHAR_DOT);
      return c;
   endfunction

   task automatic send_random_string(input string_end_type ending);
      logic [7:0] q;
      logic [7:0] c;
      q = $urandom_range(1) ? stt_pkg::CHAR_DQUOTE : stt_pkg::CHAR_SQUOTE;
      send_char(q);
      repeat ($urandom_range(6)) begin
         do c = 8'($urandom_range(255)); while (c == q || c == stt_pkg::CHAR_NEWLINE);
         send_char(c);
      end
      case (ending)
         CLOSE_QUOTE:   send_char(q);
         CLOSE_NEWLINE: send_char(stt_pkg::CHAR_NEWLINE);
         default:       send_end();
      endcase
   endtask

   task automatic send_random_number();
      if ($urandom_range(3) == 0) begin
         send_char(stt_pkg::CHAR_ZERO);
      end else begin
         send_char(8'(stt_pkg::CHAR_ZERO + $urandom_range(9, 1)));
         repeat ($urandom_range(4)) send_char(random_digit());
      end
      if ($urandom_range(1)) begin
         send_char(stt_pkg::CHAR_DOT);
         repeat ($urandom_range(3)) send_char(random_digit());
      end
      send_char(pick_delimiter(1'b1));
   endtask

   // malformed input: the error result, up to three random beats, usually an end-of-input restart
   task automatic send_broken_sequence();
      logic [7:0] c;
      case ($urandom_range(4))
         0: begin
            send_char(stt_pkg::CHAR_ZERO);
            send_char(random_digit());
         end
         1: begin
            send_char(random_digit());
            send_char(stt_pkg::CHAR_DOT);
            send_char(random_digit());
            send_char(stt_pkg::CHAR_DOT);
         end
         2: begin
            send_char(random_digit());
            do c = random_word_char(); while (digit_char(c));
            send_char(c);
         end
         3: send_random_string(CLOSE_NEWLINE);
         default: send_random_string(CLOSE_END);
      endcase
      repeat ($urandom_range(3)) send_char(8'($urandom_range(255)));
      if ($urandom_range(9) < 7) send_end();
   endtask

   task automatic send_random_token();
      int unsigned pick;
      logic [7:0]  c;
      pick = $urandom_range(19);
      if (pick < 5) begin
         do c = random_word_char();
         while (digit_char(c) || c == stt_pkg::CHAR_DQUOTE || c == stt_pkg::CHAR_SQUOTE);
         send_char(c);
         repeat ($urandom_range(5)) send_char(random_word_char());
         send_char(pick_delimiter(1'b0));
      end else if (pick < 7) begin
         case ($urandom_range(5))
            0: send_text("va");
            1: send_text("vars");
            2: send_text("v");
            3: send_text("vaa");
            default: send_text("var");
         endcase
         send_char(pick_delimiter(1'b0));
      end else if (pick < 10) begin
         send_random_number();
      end else if (pick < 12) begin
         send_random_string(CLOSE_QUOTE);
         if ($urandom_range(1)) send_char(pick_delimiter(1'b0));
      end else if (pick < 14) begin
         send_char(pick_operator());
      end else if (pick < 16) begin
         send_char(pick_separator());
      end else if (pick == 16) begin
         repeat ($urandom_range(3, 1))
            send_char($urandom_range(1) ? stt_pkg::CHAR_SPACE : stt_pkg::CHAR_NEWLINE);
      end else if (pick == 17) begin
         send_char(8'($urandom_range(255)));
      end else if (pick == 18) begin
         send_broken_sequence();
      end else begin
         send_end();
      end
   endtask

   task automatic test_token_classes();
      // keyword, identifier plus separator, float plus separator
      send_text("var vars(0.5)");
      send_end();
      // a double quote, zero byte and high bytes stay inside a word
      send_text("x");
      send_char(8'h00);
      send_char(8'hFF);
      send_char(stt_pkg::CHAR_DQUOTE);
      send_char(8'h80);
      send_text("+'q' 7");
      // integer flushed by end of input
      send_end();
   endtask

   task automatic test_lexical_errors();
      send_text("07");
      send_end();
      send_text("1.2.x");
      send_end();
      send_text("9k");
      send_end();
      send_text("\"ab\n");
      send_end();
      send_text("'q");
      send_end();
      // nothing pending: no token
      send_end();
   endtask

   task automatic test_column_clipping();
      send_text("a");
      repeat (1030) send_text("b");
      send_text("(\"z\"5 \n");
      send_end();
   endtask

   task automatic test_random_stream(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned count);
      int unsigned target;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      target = chars_sent + count;
      while (chars_sent < target) send_random_token();
      send_end();
      pause_until_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_token_classes();
      test_lexical_errors();
      test_column_clipping();
      pause_until_drained();
      test_random_stream(0, 0, 15);
      test_random_stream(80, 0, 15);
      test_random_stream(0, 80, 15);
      test_random_stream(20, 20, 15);
      $display("run: %0d character beats sent, %0d tokens checked, %0d error tokens",
               chars_sent, tokens_checked, error_tokens_seen);
      $display("run: all token classes, lexical errors, column clipping,"
               , " four idle and stall mixes");
      if (error_count == 0)
         $display("** source_text_tokenizer: PASSED **");
      else
         $display("** source_text_tokenizer: FAILED **");
      $finish;
   end

endmodule
